[src/urd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urd_pkg: shared types and constants for the unsigned restoring divider
// Field width of the ports, default operand width and the control bundle
// that the sequencer sends down the row of divider cells.
// ----------------------------------------------------------------------------
package urd_pkg;

  // width of every data port
  localparam int FIELD_W   = 64;
  // default operand width
  localparam int DEF_WIDTH = 64;

  // control from the sequencer to every cell
  typedef struct packed {
    logic load;  // capture a new dividend and divisor
    logic step;  // one shift-subtract iteration
  } ctrl_t;

endpackage

[src/unsigned_restoring_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_restoring_divider: unsigned shift-subtract divider
// Row of WIDTH bit cells computing quotient and remainder, one quotient bit
// per cycle; zero divisor gives zero results and a flag.
// ----------------------------------------------------------------------------
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------
//   req     | req_valid, req_stall  | dividend, divisor
//   rsp     | rsp_valid, rsp_stall  | quotient_out, remainder_out,
//           |                       | divide_by_zero
//
// An accepted item loads the cells, then takes WIDTH iterations; the result
// shows once the last iteration is done and holds while rsp_stall is high.
// A new item is taken only after the result has been taken, as the single
// ripple-borrow row is used once per quotient bit.
// req_stall is high from acceptance until the result has been taken.
// Synchronous reset returns the sequencer to idle; cell data is not cleared.
// Input bits at WIDTH and above are ignored; outputs are zero there.
//
module unsigned_restoring_divider
  import urd_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [FIELD_W-1:0] dividend,
  input  logic [FIELD_W-1:0] divisor,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [FIELD_W-1:0] quotient_out,
  output logic [FIELD_W-1:0] remainder_out,
  output logic               divide_by_zero
);

  ctrl_t            ctrl;
  logic [WIDTH-1:0] rem_bits;
  logic [WIDTH-1:0] quo_bits;
  logic [WIDTH-1:0] den_bits;
  logic [WIDTH-1:0] shift_vec;
  logic [WIDTH-1:0] quo_in_vec;
  logic [WIDTH:0]   borrow;
  logic             take;
  logic             dz;

  // sequencer
  urd_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctrl      (ctrl)
  );

  // shifted remainder and quotient paths between neighbors
  assign shift_vec  = {rem_bits[WIDTH-2:0], quo_bits[WIDTH-1]};
  assign quo_in_vec = {quo_bits[WIDTH-2:0], take};
  assign borrow[0]  = 1'b0;
  // difference is non-negative when the shifted-out top bit is set or no borrow
  assign take       = rem_bits[WIDTH-1] | ~borrow[WIDTH];

  // row of bit cells
  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    urd_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load_num   (dividend[i]),
      .load_den   (divisor[i]),
      .shift_in   (shift_vec[i]),
      .quo_in     (quo_in_vec[i]),
      .borrow_in  (borrow[i]),
      .take       (take),
      .borrow_out (borrow[i+1]),
      .rem_bit    (rem_bits[i]),
      .quo_bit    (quo_bits[i]),
      .den_bit    (den_bits[i])
    );
  end

  // zero divisor flag, captured with the item
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dz <= (divisor[WIDTH-1:0] == '0);
    end
  end

  // result
  assign divide_by_zero = dz;
  assign quotient_out   = dz ? '0 : FIELD_W'(quo_bits);
  assign remainder_out  = dz ? '0 : FIELD_W'(rem_bits);

  // checks
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("input accepted while a result is pending");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> !rsp_valid)
    else $error("result shown right after acceptance");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !dz) |-> (rem_bits < den_bits))
    else $error("remainder not below divisor");

  a_result_retires: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall) |=> !rsp_valid)
    else $error("result repeated after being taken");

endmodule

[src/urd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urd_cell: one bit slice of the divider
// Holds one bit of partial remainder, quotient/dividend and divisor. Computes
// its bit of the trial difference with a ripple borrow to the next cell.
// ----------------------------------------------------------------------------
module urd_cell
  import urd_pkg::*;
(
  input  logic  clk,
  input  ctrl_t ctrl,
  input  logic  load_num,    // dividend bit at load
  input  logic  load_den,    // divisor bit at load
  input  logic  shift_in,    // shifted remainder bit from the lower neighbor
  input  logic  quo_in,      // quotient bit from the lower neighbor
  input  logic  borrow_in,
  input  logic  take,        // trial difference is non-negative
  output logic  borrow_out,
  output logic  rem_bit,
  output logic  quo_bit,
  output logic  den_bit
);

  logic diff;

  // trial subtract, one bit
  assign diff       = shift_in ^ den_bit ^ borrow_in;
  assign borrow_out = (~shift_in & (den_bit | borrow_in)) | (den_bit & borrow_in);

  // bit state: restore or keep difference, shift quotient along
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem_bit <= 1'b0;
      quo_bit <= load_num;
      den_bit <= load_den;
    end else if (ctrl.step) begin
      rem_bit <= take ? diff : shift_in;
      quo_bit <= quo_in;
    end
  end

endmodule

[src/urd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urd_ctrl: sequencer of the divider
// Accepts one item, runs WIDTH iterations through the cell row and holds the
// result until it is taken.
// ----------------------------------------------------------------------------
module urd_ctrl
  import urd_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
)(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  output logic  rsp_valid,
  input  logic  rsp_stall,
  output ctrl_t ctrl
);

  localparam int CW = $clog2(WIDTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [CW-1:0] cnt;

  assign req_stall = (state != ST_IDLE);
  assign rsp_valid = (state == ST_DONE);
  assign ctrl.load = (state == ST_IDLE) && req_valid;
  assign ctrl.step = (state == ST_BUSY);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_BUSY;
      end
      ST_BUSY: begin
        if (cnt == CW'(1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (ctrl.load) begin
        cnt <= CW'(WIDTH);
      end else if (ctrl.step) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

endmodule
